// ----- src/pit_pkg.sv -----
package pit_pkg;

    // Bus command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Register select codes
    localparam logic [2:0] SEL_LOAD   = 3'd0;
    localparam logic [2:0] SEL_COUNT  = 3'd1;
    localparam logic [2:0] SEL_CTRL   = 3'd2;
    localparam logic [2:0] SEL_FLAG   = 3'd3;
    localparam logic [2:0] SEL_MODULE = 3'd4;

    // Number of interrupt lines brought out
    localparam int IRQ_LINES = 4;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  channel;
        logic [2:0]  reg_select;
        logic [31:0] write_data;
        logic        debug_halt;
    } pit_in_t;

    typedef struct packed {
        logic [31:0]          read_data;
        logic [IRQ_LINES-1:0] irq_lines;
    } pit_out_t;

endpackage

// ----- src/periodic_interrupt_timer_core.sv -----
// Each accepted item's result is captured in the output register.
// Throughput: one item per cycle; each item updates the channel registers in a
// single pass of logic. The input stalls only while a result is held downstream,
// and a new item is taken in the same cycle the waiting result is taken.
// Reset (aresetn low, synchronous): all channels cleared and disabled, load and
// count zero, flags clear, module disabled and freeze off; no result pending.
module periodic_interrupt_timer_core import pit_pkg::*; #(
    parameter int CHANNELS    = 4,
    parameter int COUNT_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pit_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pit_out_t m_data
);

    logic [CHANNELS-1:0][COUNT_WIDTH-1:0] load_reg, load_next;
    logic [CHANNELS-1:0][COUNT_WIDTH-1:0] count_reg, count_next;
    logic [CHANNELS-1:0] enable_reg, enable_next;
    logic [CHANNELS-1:0] irq_en_reg, irq_en_next;
    logic [CHANNELS-1:0] flag_reg, flag_next;
    logic                disable_reg, disable_next;
    logic                freeze_reg, freeze_next;

    logic     m_valid_reg, m_valid_next;
    pit_out_t m_data_reg, m_data_next;

    logic                 accept;
    logic                 counting;
    logic [31:0]          rd_data;
    logic [IRQ_LINES-1:0] irq_en_low;

    // Take a new item whenever the output register is empty or draining
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign counting = !(disable_reg || (freeze_reg && s_data.debug_halt));

    // Apply one item to the channel state and build its result
    always_comb begin
        load_next    = load_reg;
        count_next   = count_reg;
        enable_next  = enable_reg;
        irq_en_next  = irq_en_reg;
        flag_next    = flag_reg;
        disable_next = disable_reg;
        freeze_next  = freeze_reg;
        rd_data      = '0;

        if (accept) begin
            unique case (s_data.command)
                CMD_TICK: begin
                    if (counting) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (enable_reg[c]) begin
                                if (count_reg[c] == '0) begin
                                    count_next[c] = load_reg[c];
                                    flag_next[c]  = 1'b1;
                                end else begin
                                    count_next[c] = count_reg[c] - COUNT_WIDTH'(1);
                                end
                            end
                        end
                    end
                end
                CMD_READ: begin
                    if (s_data.reg_select == SEL_MODULE) begin
                        rd_data = {30'd0, disable_reg, freeze_reg};
                    end else begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (int'(s_data.channel) == c) begin
                                unique case (s_data.reg_select)
                                    SEL_LOAD:  rd_data = 32'(load_reg[c]);
                                    SEL_COUNT: rd_data = 32'(count_reg[c]);
                                    SEL_CTRL:  rd_data = {30'd0, irq_en_reg[c], enable_reg[c]};
                                    SEL_FLAG:  rd_data = {31'd0, flag_reg[c]};
                                    default:   rd_data = '0;
                                endcase
                            end
                        end
                    end
                end
                CMD_WRITE: begin
                    if (s_data.reg_select == SEL_MODULE) begin
                        freeze_next  = s_data.write_data[0];
                        disable_next = s_data.write_data[1];
                    end else begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (int'(s_data.channel) == c) begin
                                unique case (s_data.reg_select)
                                    SEL_LOAD: load_next[c] = COUNT_WIDTH'(s_data.write_data);
                                    SEL_CTRL: begin
                                        // Load the count on a rising enable
                                        if (s_data.write_data[0] && !enable_reg[c]) begin
                                            count_next[c] = load_reg[c];
                                        end
                                        enable_next[c] = s_data.write_data[0];
                                        irq_en_next[c] = s_data.write_data[1];
                                    end
                                    SEL_FLAG: begin
                                        if (s_data.write_data[0]) begin
                                            flag_next[c] = 1'b0;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        // Build the result: read data from the current state, interrupt lines from the updated state
        m_data_next.read_data = rd_data;
        m_data_next.irq_lines = '0;
        irq_en_low            = '0;
        for (int c = 0; c < CHANNELS && c < IRQ_LINES; c++) begin
            m_data_next.irq_lines[c] = flag_next[c] && irq_en_next[c];
            irq_en_low[c]            = irq_en_reg[c];
        end
    end

    // Hold the result until taken, load a new one on accept
    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg    <= '0;
            count_reg   <= '0;
            enable_reg  <= '0;
            irq_en_reg  <= '0;
            flag_reg    <= '0;
            disable_reg <= 1'b1;
            freeze_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            load_reg    <= load_next;
            count_reg   <= count_next;
            enable_reg  <= enable_next;
            irq_en_reg  <= irq_en_next;
            flag_reg    <= flag_next;
            disable_reg <= disable_next;
            freeze_reg  <= freeze_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A pending interrupt line implies its channel's interrupt enable
    a_irq_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg.irq_lines & ~irq_en_low) == '0))
        else $error("irq line set without interrupt enable");

    // A tick while the module is disabled leaves every count alone
    a_disabled_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.command == CMD_TICK && disable_reg) |=> $stable(count_reg))
        else $error("count moved while module disabled");

    // Only reads return data
    a_nonread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.command != CMD_READ) |=> (m_data_reg.read_data == '0))
        else $error("nonzero read data for a non-read item");

    // A tick never clears a flag
    a_tick_keeps_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.command == CMD_TICK) |=> ((flag_reg & $past(flag_reg)) == $past(flag_reg)))
        else $error("flag cleared by a tick");

endmodule
